/* hdl/ncc_pkg.sv */
// Shared types and constants of the nearest-centroid classifier.
package ncc_pkg;

  localparam int KIND_W    = 2;
  localparam int CLUSTER_W = 4;
  localparam int DIM_W     = 4;
  localparam int DIST_W    = 36;
  localparam int CFG_W     = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;

  // request kinds; the fourth code is ignored
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD     = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_UPDATE   = 2'd2
  } kind_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_CLUSTERS_IN_USE = 1'b0
  } reg_idx_t;

endpackage

/* hdl/nearest_centroid_classifier_core.sv */
// Nearest-centroid classifier core: centroid memory, distance accumulators, search.
//
// Requests enter on item_valid/item_ready with kind, cluster, dim and value.
// A load request writes one centroid word and gives no result. A classify
// request streams one feature component past every centroid and adds its
// squared difference into each cluster's accumulator (overwritten at dim 0);
// the request at the last dimension yields the nearest active cluster and
// its squared distance. An update request averages (floor) one centroid word
// with the value and reports the cluster, distance 0. Results leave on
// result_valid/result_ready.
// Sequence: a load is written at accept; an update passes through the read,
//   write-back and result hand-off states; a classify issues one centroid
//   read per cycle, then the 3-stage subtract / square / accumulate pipeline
//   drains; the last dimension then adds the result hand-off state.
//   One request is in work at a time; item_ready is high only when idle.
// Reset: rst clears control, sets clusters_in_use to 16, accumulators read 0;
//   centroid words are undefined until loaded. Config at APB byte address 0.
// Stall: a result waits in the output register while new requests are
//   taken; a request that makes a second result waits until the first goes.
module nearest_centroid_classifier_core #(
  parameter int NUM_CLUSTERS = 16,
  parameter int NUM_DIMS     = 13,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [ncc_pkg::KIND_W-1:0]        kind,
  input  logic [ncc_pkg::CLUSTER_W-1:0]     cluster,
  input  logic [ncc_pkg::DIM_W-1:0]         dim,
  input  logic signed [VALUE_WIDTH-1:0]     value,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [ncc_pkg::CLUSTER_W-1:0]     nearest_cluster,
  output logic [ncc_pkg::DIST_W-1:0]        squared_distance,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ncc_pkg::APB_AW-1:0]        paddr,
  input  logic [ncc_pkg::APB_DW-1:0]        pwdata,
  output logic [ncc_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import ncc_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int DEPTH = NUM_CLUSTERS * NUM_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam logic [CW-1:0] LAST_TAG = CW'(NUM_CLUSTERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_UPD_READ,
    ST_UPD_WRITE,
    ST_FINISH
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] clusters_in_use;
  logic             cfg_we;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready && (cfg_idx == REG_CLUSTERS_IN_USE);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_CLUSTERS_IN_USE: prdata = APB_DW'(clusters_in_use);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  logic          item_acc;
  logic          dim_ok;
  logic          cl_ok;
  logic [AW-1:0] word_addr;

  assign item_ready = (state == ST_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign dim_ok     = 32'(dim) < NUM_DIMS;
  assign cl_ok      = 32'(cluster) < NUM_CLUSTERS;
  assign word_addr  = AW'(32'(cluster) * NUM_DIMS + 32'(dim));

  // ---------------------------------------------------------------------
  // Centroid memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [VW-1:0] cmem [DEPTH];
  logic [VW-1:0] c_rdata;
  logic [VW-1:0] c_wdata;
  logic [AW-1:0] c_waddr;
  logic          c_we;
  logic [AW-1:0] iss_addr;   // read address for classify sweep and update

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_rdata <= cmem[iss_addr];
  end

  // ---------------------------------------------------------------------
  // Accumulator memory, with per-entry valid bits standing for reset zero
  // ---------------------------------------------------------------------
  logic [DIST_W-1:0]       amem [NUM_CLUSTERS];
  logic [DIST_W-1:0]       a_rdata;
  logic [NUM_CLUSTERS-1:0] acc_valid;
  logic [CW-1:0]           iss_tag;
  logic                    iss_done;

  // pipeline registers
  logic              p1_v, p2_v, p3_v;
  logic [CW-1:0]     p1_tag, p2_tag, p3_tag;
  logic [VW-1:0]     p2_ad;
  logic [DIST_W-1:0] p2_acc, p3_acc;
  logic [DIST_W-1:0] p3_sq;

  // latched request
  logic [VW-1:0]        value_r;
  logic [DIM_W-1:0]     dim_r;
  logic [CLUSTER_W-1:0] cluster_r;

  // search and pending result
  logic [CW-1:0]        best_tag;
  logic [DIST_W-1:0]    best_dist;
  logic [CLUSTER_W-1:0] res_cluster;
  logic [DIST_W-1:0]    res_dist;

  // stage 1: absolute difference
  logic [VW:0]   s1_diff;
  logic [VW:0]   s1_neg;
  logic [VW-1:0] s1_ad;
  // stage 2: square and clamp
  logic [2*VW-1:0] s2_prod;
  logic [63:0]     s2_prod64;
  logic [DIST_W-1:0] s2_sq;
  // stage 3: accumulate
  logic [DIST_W:0]   s3_sum37;
  logic [DIST_W-1:0] s3_sum;
  logic              s3_search;
  logic              s3_better;
  logic              dim_first;
  logic              dim_last;
  // update average
  logic [VW:0]       u_sum;

  assign dim_first = (dim_r == '0);
  assign dim_last  = (32'(dim_r) == NUM_DIMS - 1);

  always_ff @(posedge clk) begin
    if (p3_v) begin
      amem[p3_tag] <= s3_sum;
    end
    a_rdata <= amem[iss_tag];
  end

  always_comb begin
    s1_diff = {c_rdata[VW-1], c_rdata};
    s1_diff = {value_r[VW-1], value_r} - s1_diff;
    s1_neg  = (VW+1)'(0) - s1_diff;
    s1_ad   = s1_diff[VW] ? s1_neg[VW-1:0] : s1_diff[VW-1:0];

    s2_prod   = p2_ad * p2_ad;
    s2_prod64 = 64'(s2_prod);
    s2_sq     = (s2_prod64 > 64'(DIST_MAX)) ? DIST_MAX : s2_prod64[DIST_W-1:0];

    s3_sum37 = {1'b0, p3_acc} + {1'b0, p3_sq};
    if (dim_first) begin
      s3_sum = p3_sq;
    end else begin
      s3_sum = s3_sum37[DIST_W] ? DIST_MAX : s3_sum37[DIST_W-1:0];
    end
    // only the first clusters_in_use (at least one) take part
    s3_search = (p3_tag == '0) || (32'(p3_tag) < 32'(clusters_in_use));
    s3_better = s3_search && ((p3_tag == '0) || (s3_sum < best_dist));

    // floor average: arithmetic shift of the widened sum
    u_sum = {value_r[VW-1], value_r} + {c_rdata[VW-1], c_rdata};
  end

  // centroid write port: load at accept, update write-back
  always_comb begin
    c_we    = 1'b0;
    c_waddr = word_addr;
    c_wdata = value;
    if (state == ST_UPD_WRITE) begin
      c_we    = 1'b1;
      c_waddr = iss_addr;
      c_wdata = u_sum[VW:1];
    end else if (item_acc && dim_ok && cl_ok && (kind == KIND_LOAD)) begin
      c_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Control, pipeline and output registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      clusters_in_use <= CFG_RESET;
      acc_valid       <= '0;
      p1_v            <= 1'b0;
      p2_v            <= 1'b0;
      p3_v            <= 1'b0;
      iss_done        <= 1'b0;
      iss_tag         <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        clusters_in_use <= pwdata[CFG_W-1:0];
      end

      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      // pipeline advance
      p1_v   <= 1'b0;
      p2_v   <= p1_v;
      p3_v   <= p2_v;
      p2_tag <= p1_tag;
      p3_tag <= p2_tag;
      p2_ad  <= s1_ad;
      p2_acc <= acc_valid[p1_tag] ? a_rdata : '0;
      p3_acc <= p2_acc;
      p3_sq  <= s2_sq;

      if (p3_v) begin
        acc_valid[p3_tag] <= 1'b1;
        if (s3_better) begin
          best_tag  <= p3_tag;
          best_dist <= s3_sum;
        end
      end

      case (state)
        ST_IDLE: begin
          if (item_acc) begin
            value_r   <= value;
            dim_r     <= dim;
            cluster_r <= cluster;
            iss_tag   <= '0;
            iss_done  <= 1'b0;
            if (dim_ok) begin
              if (kind == KIND_CLASSIFY) begin
                iss_addr <= AW'(dim);
                state    <= ST_CLASSIFY;
              end else if ((kind == KIND_UPDATE) && cl_ok) begin
                iss_addr <= word_addr;
                state    <= ST_UPD_READ;
              end
            end
          end
        end

        ST_CLASSIFY: begin
          if (!iss_done) begin
            p1_v     <= 1'b1;
            p1_tag   <= iss_tag;
            iss_addr <= iss_addr + AW'(NUM_DIMS);
            if (iss_tag == LAST_TAG) begin
              iss_done <= 1'b1;
            end else begin
              iss_tag <= iss_tag + 1'b1;
            end
          end
          if (p3_v && (p3_tag == LAST_TAG)) begin
            if (dim_last) begin
              res_cluster <= s3_better ? CLUSTER_W'(p3_tag) : CLUSTER_W'(best_tag);
              res_dist    <= s3_better ? s3_sum : best_dist;
              state       <= ST_FINISH;
            end else begin
              state <= ST_IDLE;
            end
          end
        end

        ST_UPD_READ: begin
          state <= ST_UPD_WRITE;
        end

        ST_UPD_WRITE: begin
          res_cluster <= cluster_r;
          res_dist    <= '0;
          state       <= ST_FINISH;
        end

        ST_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid     <= 1'b1;
            nearest_cluster  <= res_cluster;
            squared_distance <= res_dist;
            state            <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a request is only taken once the previous sweep has fully drained
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    item_acc |-> !p1_v && !p2_v && !p3_v)
    else $error("request accepted with distance pipeline busy");

  // the accumulator being written is never the one being read in the sweep
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLASSIFY && !iss_done && p3_v) |-> iss_tag != p3_tag)
    else $error("accumulator read and write collide");

  // result hand-off happens only with an empty pipeline
  a_finish_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !p1_v && !p2_v && !p3_v)
    else $error("result staged while pipeline still active");

  // an update result always reports zero distance
  a_update_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD_WRITE) |=> (res_dist == '0) && (res_cluster == $past(cluster_r)))
    else $error("update result staged incorrectly");
`endif

endmodule
